### src/dertlv_pkg.sv
// ----------------------------------------------------------------------------
// dertlv_pkg
// Shared types and constants for the DER primitive TLV encoder.
// ----------------------------------------------------------------------------
package dertlv_pkg;

  // item modes
  localparam logic [2:0] MODE_BOOLEAN = 3'd0;
  localparam logic [2:0] MODE_INTEGER = 3'd1;
  localparam logic [2:0] MODE_OCTSTR  = 3'd2;
  localparam logic [2:0] MODE_CONTENT = 3'd3;
  localparam logic [2:0] MODE_NULL    = 3'd4;
  localparam logic [2:0] MODE_IDENT   = 3'd5;
  localparam logic [2:0] MODE_LENGTH  = 3'd6;

  // identifier octets and fixed contents
  localparam logic [7:0] TAG_BOOLEAN = 8'h01;
  localparam logic [7:0] TAG_INTEGER = 8'h02;
  localparam logic [7:0] TAG_OCTSTR  = 8'h04;
  localparam logic [7:0] TAG_NULL    = 8'h05;
  localparam logic [7:0] BOOL_TRUE   = 8'hFF;
  localparam logic [7:0] BOOL_FALSE  = 8'h00;
  localparam logic [7:0] SHORT_MAX   = 8'h7F;

  // long form length prefixes
  localparam logic [7:0] LEN_LONG_1 = 8'h81;
  localparam logic [7:0] LEN_LONG_2 = 8'h82;
  localparam logic [7:0] LEN_LONG_3 = 8'h83;
  localparam logic [7:0] LEN_LONG_4 = 8'h84;

  // most octets one item can cause
  localparam int DESC_BYTES = 6;
  localparam int CNT_W      = $clog2(DESC_BYTES + 1);

  // queue between front and back
  localparam int FIFO_DEPTH = 2;
  localparam int PTR_W      = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int FILL_W     = $clog2(FIFO_DEPTH + 1);

  typedef struct packed {
    logic [2:0]         mode;
    logic               bool_value;
    logic signed [31:0] int_value;
    logic [31:0]        length_value;
    logic [7:0]         data_byte;
    logic [1:0]         id_class;
    logic               constructed;
    logic [4:0]         id_number;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_item;
  } out_item_t;

  // octets of one item, entry 0 goes out first
  typedef logic [DESC_BYTES-1:0][7:0] byte_arr_t;

  typedef struct packed {
    byte_arr_t        bytes;
    logic [CNT_W-1:0] count;
  } desc_t;

  typedef struct packed {
    logic empty;
    logic full;
  } fifo_stat_t;

endpackage

### src/der_primitive_tlv_encoder.sv
// ----------------------------------------------------------------------------
// der_primitive_tlv_encoder
// Encodes DER primitives and emits them one octet per result item.
//
//   channel | direction | payload    | handshake
//   in      | input     | in_item_t  | in_valid / in_ready
//   out     | output    | out_item_t | out_valid / out_ready
//
// An item causes 1 to 6 octets (6 at most, an integer or an octet string
// header with a long length); the serialiser sends one octet per cycle while
// out_ready does not stall the output. The front takes a new item each cycle
// while the two-entry queue has room. Mode 7 is taken and causes nothing.
// Reset is synchronous and empties the queue and the output register.
// ----------------------------------------------------------------------------
module der_primitive_tlv_encoder
  import dertlv_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_item
);

  desc_t      front_desc;
  desc_t      head_desc;
  logic       has_octets;
  logic       push, pop;
  fifo_stat_t stat;

  // classify
  dertlv_front u_front (
    .item       (in_item),
    .desc       (front_desc),
    .has_octets (has_octets)
  );

  assign in_ready = !stat.full;
  assign push     = in_valid && in_ready && has_octets;

  // queue
  dertlv_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_desc (front_desc),
    .pop       (pop),
    .head_desc (head_desc),
    .stat      (stat)
  );

  // serialise
  dertlv_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head_desc (head_desc),
    .stat      (stat),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
  );

endmodule

### src/dertlv_front.sv
// ----------------------------------------------------------------------------
// dertlv_front
// Classifies an input item and builds the list of octets it causes.
// ----------------------------------------------------------------------------
module dertlv_front
  import dertlv_pkg::*;
(
  input  in_item_t item,
  output desc_t    desc,
  output logic     has_octets
);

  logic [4:0][7:0]  len_bytes;
  logic [CNT_W-1:0] len_count;
  logic [31:0]      ival;

  assign ival = item.int_value;

  // length encoding, short or long form
  always_comb begin
    len_bytes = '0;
    len_count = CNT_W'(1);
    if (item.length_value <= {24'd0, SHORT_MAX}) begin
      len_bytes[0] = item.length_value[7:0];
      len_count    = CNT_W'(1);
    end else if (item.length_value[31:8] == 24'd0) begin
      len_bytes[0] = LEN_LONG_1;
      len_bytes[1] = item.length_value[7:0];
      len_count    = CNT_W'(2);
    end else if (item.length_value[31:16] == 16'd0) begin
      len_bytes[0] = LEN_LONG_2;
      len_bytes[1] = item.length_value[15:8];
      len_bytes[2] = item.length_value[7:0];
      len_count    = CNT_W'(3);
    end else if (item.length_value[31:24] == 8'd0) begin
      len_bytes[0] = LEN_LONG_3;
      len_bytes[1] = item.length_value[23:16];
      len_bytes[2] = item.length_value[15:8];
      len_bytes[3] = item.length_value[7:0];
      len_count    = CNT_W'(4);
    end else begin
      len_bytes[0] = LEN_LONG_4;
      len_bytes[1] = item.length_value[31:24];
      len_bytes[2] = item.length_value[23:16];
      len_bytes[3] = item.length_value[15:8];
      len_bytes[4] = item.length_value[7:0];
      len_count    = CNT_W'(5);
    end
  end

  // octet list per mode
  always_comb begin
    desc       = '0;
    has_octets = 1'b1;
    case (item.mode)
      MODE_BOOLEAN: begin
        desc.bytes[0] = TAG_BOOLEAN;
        desc.bytes[1] = 8'h01;
        desc.bytes[2] = item.bool_value ? BOOL_TRUE : BOOL_FALSE;
        desc.count    = CNT_W'(3);
      end
      MODE_INTEGER: begin
        desc.bytes[0] = TAG_INTEGER;
        // fewest octets whose top bit still carries the sign
        if ((ival[31:7] == '0) || (ival[31:7] == '1)) begin
          desc.bytes[1] = 8'd1;
          desc.bytes[2] = ival[7:0];
          desc.count    = CNT_W'(3);
        end else if ((ival[31:15] == '0) || (ival[31:15] == '1)) begin
          desc.bytes[1] = 8'd2;
          desc.bytes[2] = ival[15:8];
          desc.bytes[3] = ival[7:0];
          desc.count    = CNT_W'(4);
        end else if ((ival[31:23] == '0) || (ival[31:23] == '1)) begin
          desc.bytes[1] = 8'd3;
          desc.bytes[2] = ival[23:16];
          desc.bytes[3] = ival[15:8];
          desc.bytes[4] = ival[7:0];
          desc.count    = CNT_W'(5);
        end else begin
          desc.bytes[1] = 8'd4;
          desc.bytes[2] = ival[31:24];
          desc.bytes[3] = ival[23:16];
          desc.bytes[4] = ival[15:8];
          desc.bytes[5] = ival[7:0];
          desc.count    = CNT_W'(6);
        end
      end
      MODE_OCTSTR: begin
        desc.bytes[0] = TAG_OCTSTR;
        for (int j = 0; j < 5; j++) begin
          desc.bytes[j+1] = len_bytes[j];
        end
        desc.count = len_count + CNT_W'(1);
      end
      MODE_CONTENT: begin
        desc.bytes[0] = item.data_byte;
        desc.count    = CNT_W'(1);
      end
      MODE_NULL: begin
        desc.bytes[0] = TAG_NULL;
        desc.bytes[1] = 8'h00;
        desc.count    = CNT_W'(2);
      end
      MODE_IDENT: begin
        desc.bytes[0] = {item.id_class, item.constructed, item.id_number};
        desc.count    = CNT_W'(1);
      end
      MODE_LENGTH: begin
        for (int j = 0; j < 5; j++) begin
          desc.bytes[j] = len_bytes[j];
        end
        desc.count = len_count;
      end
      default: begin
        // unused mode causes no octets
        has_octets = 1'b0;
      end
    endcase
  end

endmodule

### src/dertlv_fifo.sv
// ----------------------------------------------------------------------------
// dertlv_fifo
// Short queue of octet lists between the classifier and the serialiser.
// ----------------------------------------------------------------------------
module dertlv_fifo
  import dertlv_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  desc_t      push_desc,
  input  logic       pop,
  output desc_t      head_desc,
  output fifo_stat_t stat
);

  desc_t             mem_r [FIFO_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic              do_push, do_pop;

  assign stat.empty = (fill_r == '0);
  assign stat.full  = (fill_r == FILL_W'(FIFO_DEPTH));
  assign do_push    = push && !stat.full;
  assign do_pop     = pop && !stat.empty;
  assign head_desc  = mem_r[rd_ptr_r];

  // pointer and fill updates
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    fill_nxt   = fill_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      fill_nxt = fill_r + FILL_W'(1);
    end else if (do_pop && !do_push) begin
      fill_nxt = fill_r - FILL_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  // storage, no reset needed
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_desc;
    end
  end

endmodule

### src/dertlv_back.sv
// ----------------------------------------------------------------------------
// dertlv_back
// Serialises the queued octet lists into one registered octet per cycle while out_ready does not stall the output.
// ----------------------------------------------------------------------------
module dertlv_back
  import dertlv_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  desc_t      head_desc,
  input  fifo_stat_t stat,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_ready,
  output out_item_t  out_item
);

  logic [CNT_W-1:0] idx_r, idx_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_item_r;
  logic             emit, last;

  // send when the output slot is free or being emptied
  assign emit = !stat.empty && (!out_valid_r || out_ready);
  assign last = (idx_r == head_desc.count - CNT_W'(1));
  assign pop  = emit && last;

  always_comb begin
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r;
    if (emit) begin
      idx_nxt       = last ? '0 : idx_r + CNT_W'(1);
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // output payload register
  always_ff @(posedge clk) begin
    if (emit) begin
      out_item_r.out_byte     <= head_desc.bytes[idx_r];
      out_item_r.last_of_item <= last;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule
